@@ rtl/core/frustum_triangle_cull_top_macros.svh @@
// Assertion macros shared by the frustum culling RTL.
`ifndef FRUSTUM_TRIANGLE_CULL_TOP_MACROS_SVH
`define FRUSTUM_TRIANGLE_CULL_TOP_MACROS_SVH

// Same-cycle implication, sampled on clk_i and switched off during reset.
`define FTC_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i and switched off during reset.
`define FTC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/core/ftc_pkg.sv @@
// Package of types and constants for the frustum culling block.
package ftc_pkg;

  // Field widths of the stream items.
  localparam int unsigned IDX_W      = 12;
  localparam int unsigned COORD_W    = 16;
  localparam int unsigned COEF_W     = 16;
  localparam int unsigned TOL_W      = 16;
  localparam int unsigned IN_TDATA_W = 96;
  localparam int unsigned OUT_TDATA_W = 8;

  // Flag store geometry.
  localparam int unsigned VTX_DEPTH   = 4096;
  localparam int unsigned CORNER_CNT  = 3;
  localparam int unsigned PLANE_CNT   = 6;

  // Configuration port.
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 64;
  localparam logic [TOL_W-1:0] TOL_RESET = TOL_W'(7);

  // Product of a Q8.8 coefficient and a Q8.8 coordinate, Q16.16.
  localparam int unsigned PROD_W = COEF_W + COORD_W;
  // Three products, the scaled d term and the margin, with headroom.
  localparam int unsigned SUM_W  = PROD_W + 3;

  // Register indexes of the configuration port.
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PLANE_LEFT   = 3'd0,
    CFG_PLANE_RIGHT  = 3'd1,
    CFG_PLANE_BOTTOM = 3'd2,
    CFG_PLANE_TOP    = 3'd3,
    CFG_PLANE_NEAR   = 3'd4,
    CFG_PLANE_FAR    = 3'd5,
    CFG_TOLERANCE    = 3'd6
  } cfg_idx_e;

  // Item kind carried in tuser.
  typedef enum logic {
    KIND_VERTEX   = 1'b0,
    KIND_TRIANGLE = 1'b1
  } kind_e;

  // One plane: a, b, c, d from the lowest bits up, each signed Q8.8.
  typedef logic [3:0][COEF_W-1:0] plane_t;

  // One accepted input item.
  typedef struct packed {
    kind_e                             kind;
    logic [IDX_W-1:0]                  vidx;
    logic [CORNER_CNT-1:0][COORD_W-1:0] coord;
    logic [CORNER_CNT-1:0][IDX_W-1:0]  corner;
  } item_t;

endpackage

@@ rtl/core/frustum_triangle_cull_top.sv @@
// Top level of the view-frustum culling block for vertices and triangles.
//
// Vertex and triangle transactions stream in on the slave side, one per clock, and each
// gives exactly one result transaction on the master side after passing all three
// pipeline registers in turn. The pipeline has an input register, a stage that
// registers the eighteen coefficient products with the triangle's flag reads, and the
// result register, where the six plane sums are compared with the margin. Sustained
// throughput is one transaction per cycle; a stall on the master side holds the whole
// pipeline. Inside flags sit in three copies of a 4096 by 1 memory, one read port per
// triangle corner, and a triangle sees the flag of the vertex directly ahead of it
// through a bypass register. A triangle corner that no vertex has written yet reads as
// an arbitrary value. Configuration writes are always taken and must happen while idle.
module frustum_triangle_cull_top (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // Configuration write channel.
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [ftc_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [ftc_pkg::CFG_DATA_W-1:0]    cfg_data_i,
  // Input stream.
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // tdata from bit 0: vertex_index[11:0], x_coord[27:12], y_coord[43:28],
  // z_coord[59:44], corner_a[71:60], corner_b[83:72], corner_c[95:84]
  input  logic [ftc_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
  // tuser from bit 0: kind
  input  logic [0:0]                        s_axis_tuser,
  // Output stream.
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // tdata from bit 0: visible, then zero padding
  output logic [ftc_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,
  // tuser from bit 0: for_triangle
  output logic [0:0]                        m_axis_tuser
);
  import ftc_pkg::*;

  // Configuration registers.
  plane_t           plane_q [PLANE_CNT];
  logic [TOL_W-1:0] tol_q;

  // Pipeline state.
  logic                              en;
  logic                              s1_v_q;
  item_t                             s1_q, s1_d;
  logic                              s2_v_q;
  kind_e                             s2_kind_q;
  logic [IDX_W-1:0]                  s2_vidx_q;
  logic [CORNER_CNT-1:0][IDX_W-1:0]  s2_corner_q;
  logic signed [PROD_W-1:0]          prod_d [PLANE_CNT][CORNER_CNT];
  logic signed [PROD_W-1:0]          prod_q [PLANE_CNT][CORNER_CNT];
  wire  [CORNER_CNT-1:0]             rd_flag;
  logic                              wr_v_q;
  logic [IDX_W-1:0]                  wr_idx_q;
  logic                              wr_flag_q;
  logic                              vtx_inside;
  logic                              tri_vis;
  logic                              out_v_q;
  logic                              out_tri_q;
  logic                              out_vis_q;
  logic                              out_vis_d;

  // The whole pipeline moves when the result register is empty or being drained.
  assign en            = !out_v_q || m_axis_tready;
  assign s_axis_tready = en;
  assign cfg_ready_o   = 1'b1;

  // Configuration register writes; an index beyond the list is dropped.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int p = 0; p < PLANE_CNT; p++) begin
        plane_q[p] <= '0;
      end
      tol_q <= TOL_RESET;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_PLANE_LEFT:   plane_q[0] <= cfg_data_i;
        CFG_PLANE_RIGHT:  plane_q[1] <= cfg_data_i;
        CFG_PLANE_BOTTOM: plane_q[2] <= cfg_data_i;
        CFG_PLANE_TOP:    plane_q[3] <= cfg_data_i;
        CFG_PLANE_NEAR:   plane_q[4] <= cfg_data_i;
        CFG_PLANE_FAR:    plane_q[5] <= cfg_data_i;
        CFG_TOLERANCE:    tol_q      <= cfg_data_i[TOL_W-1:0];
        default: ;
      endcase
    end
  end

  // Unpack the input transaction.
  always_comb begin
    s1_d.kind   = kind_e'(s_axis_tuser[0]);
    s1_d.vidx   = s_axis_tdata[IDX_W-1:0];
    s1_d.coord  = s_axis_tdata[IDX_W +: CORNER_CNT*COORD_W];
    s1_d.corner = s_axis_tdata[IDX_W+CORNER_CNT*COORD_W +: CORNER_CNT*IDX_W];
  end

  // Input register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
    end else if (en) begin
      s1_v_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s1_q <= s1_d;
    end
  end

  // Coefficient products, one multiplier per plane and axis.
  always_comb begin
    for (int p = 0; p < PLANE_CNT; p++) begin
      for (int k = 0; k < CORNER_CNT; k++) begin
        prod_d[p][k] = PROD_W'($signed(plane_q[p][k])) * PROD_W'($signed(s1_q.coord[k]));
      end
    end
  end

  // Product stage.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_v_q <= 1'b0;
    end else if (en) begin
      s2_v_q <= s1_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s2_kind_q   <= s1_q.kind;
      s2_vidx_q   <= s1_q.vidx;
      s2_corner_q <= s1_q.corner;
      prod_q      <= prod_d;
    end
  end

  // Flag memories: every copy takes each vertex write, each serves one corner.
  for (genvar k = 0; k < CORNER_CNT; k++) begin : g_flag_mem
    logic flag_mem [VTX_DEPTH];
    logic rd_q;

    always_ff @(posedge clk_i) begin
      if (en && s2_v_q && (s2_kind_q == KIND_VERTEX)) begin
        flag_mem[s2_vidx_q] <= vtx_inside;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en) begin
        rd_q <= flag_mem[s1_q.corner[k]];
      end
    end

    assign rd_flag[k] = rd_q;
  end

  // Bypass register: the write made at the edge where the triangle read the memory.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_v_q <= 1'b0;
    end else if (en) begin
      wr_v_q <= s2_v_q && (s2_kind_q == KIND_VERTEX);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      wr_idx_q  <= s2_vidx_q;
      wr_flag_q <= vtx_inside;
    end
  end

  // Plane tests: s + margin must not be negative for any plane.
  always_comb begin
    logic signed [SUM_W-1:0] sum;
    logic        [SUM_W-1:0] d_term;
    vtx_inside = 1'b1;
    for (int p = 0; p < PLANE_CNT; p++) begin
      d_term = {{(SUM_W-COEF_W-8){plane_q[p][3][COEF_W-1]}}, plane_q[p][3], 8'h00};
      sum = SUM_W'(prod_q[p][0]) + SUM_W'(prod_q[p][1]) + SUM_W'(prod_q[p][2])
          - $signed(d_term) + $signed({{(SUM_W-TOL_W){1'b0}}, tol_q});
      if (sum[SUM_W-1]) begin
        vtx_inside = 1'b0;
      end
    end
  end

  // Triangle visibility from the three corner flags, bypassed where needed.
  always_comb begin
    tri_vis = 1'b0;
    for (int k = 0; k < CORNER_CNT; k++) begin
      if (wr_v_q && (wr_idx_q == s2_corner_q[k])) begin
        tri_vis = tri_vis | wr_flag_q;
      end else begin
        tri_vis = tri_vis | rd_flag[k];
      end
    end
  end

  assign out_vis_d = (s2_kind_q == KIND_TRIANGLE) ? tri_vis : vtx_inside;

  // Result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (en) begin
      out_v_q <= s2_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_tri_q <= (s2_kind_q == KIND_TRIANGLE);
      out_vis_q <= out_vis_d;
    end
  end

  assign m_axis_tvalid = out_v_q;
  assign m_axis_tuser  = out_tri_q;
  assign m_axis_tdata  = {{(OUT_TDATA_W-1){1'b0}}, out_vis_q};

  // Checks on the pipeline and the bypass path.
  `include "frustum_triangle_cull_top_macros.svh"

  `FTC_ASSERT_IMPL(a_bypass_visible,
                   s2_v_q && (s2_kind_q == KIND_TRIANGLE) && wr_v_q && wr_flag_q
                   && (wr_idx_q == s2_corner_q[0]),
                   tri_vis, "Triangle missed the flag of the vertex just ahead")
  `FTC_ASSERT_IMPL(a_out_source, $rose(out_v_q), $past(s2_v_q),
                   "Result appeared without an item in the product stage")
  `FTC_ASSERT_NEXT(a_s1_hold, !en && s1_v_q, s1_v_q && $stable(s1_q),
                   "Input register changed during a stall")

endmodule

@@ tb/sv/tb_top.sv @@
`timescale 1ns / 1ps
// Self-checking testbench of the frustum culling block against a predictor.
module tb_top;
  import ftc_pkg::*;

  // The one register index that the block does not decode.
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED  = 3'd7;
  localparam int unsigned          CYCLE_LIMIT = 200000;
  localparam int unsigned          IDLE_PCT    = 10;

  logic                   clk_i;
  logic                   rst_ni;
  logic                   cfg_valid_i;
  logic                   cfg_ready_o;
  logic [CFG_IDX_W-1:0]   cfg_index_i;
  logic [CFG_DATA_W-1:0]  cfg_data_i;
  logic                   s_axis_tvalid;
  logic                   s_axis_tready;
  // tdata from bit 0: vertex_index, x, y, z, corner_a, corner_b, corner_c
  logic [IN_TDATA_W-1:0]  s_axis_tdata;
  // tuser from bit 0: kind
  logic [0:0]             s_axis_tuser;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready;
  // tdata from bit 0: visible, then zero padding
  logic [OUT_TDATA_W-1:0] m_axis_tdata;
  // tuser from bit 0: for_triangle
  logic [0:0]             m_axis_tuser;

  // One expected result transaction.
  typedef struct {
    logic for_triangle;
    logic visible;
  } cull_result_t;

  // Keeps its own copy of the planes, the margin and the inside flags, and the results due.
  class cull_scoreboard;
    logic [CFG_DATA_W-1:0] planes [PLANE_CNT];
    logic [TOL_W-1:0]      margin;
    bit                    flag_copy [VTX_DEPTH];
    cull_result_t          due_q [$];
    int                    errors;

    function new();
      foreach (planes[p]) planes[p] = '0;
      margin = TOL_RESET;
      errors = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] v);
      if (idx <= CFG_PLANE_FAR) begin
        planes[idx] = v;
      end else if (idx == CFG_TOLERANCE) begin
        margin = v[TOL_W-1:0];
      end
    endfunction

    // Signed distance test of one vertex against all six planes, in exact Q16.16.
    function bit vertex_in_frustum(longint x, longint y, longint z);
      longint a, b, c, d, plane_dist, lim;
      lim = margin;
      for (int p = 0; p < PLANE_CNT; p++) begin
        a = $signed(planes[p][15:0]);
        b = $signed(planes[p][31:16]);
        c = $signed(planes[p][47:32]);
        d = $signed(planes[p][63:48]);
        plane_dist = a * x + b * y + c * z - d * 256;
        if (plane_dist < -lim) return 1'b0;
      end
      return 1'b1;
    endfunction

    function void note_item(kind_e k, logic [IN_TDATA_W-1:0] data);
      cull_result_t r;
      longint x, y, z;
      if (k == KIND_VERTEX) begin
        x = $signed(data[27:12]);
        y = $signed(data[43:28]);
        z = $signed(data[59:44]);
        r.for_triangle = 1'b0;
        r.visible = vertex_in_frustum(x, y, z);
        flag_copy[data[11:0]] = r.visible;
      end else begin
        r.for_triangle = 1'b1;
        r.visible = flag_copy[data[71:60]] | flag_copy[data[83:72]] | flag_copy[data[95:84]];
      end
      due_q = {due_q, r};
    endfunction

    function void check_result(logic for_triangle, logic visible);
      cull_result_t r;
      if (due_q.size() == 0) begin
        $error("result transaction with nothing expected: for_triangle %0b visible %0b",
               for_triangle, visible);
        errors++;
        return;
      end
      r = due_q.pop_front();
      if (for_triangle !== r.for_triangle) begin
        $error("for_triangle: expected %0b, actual %0b", r.for_triangle, for_triangle);
        errors++;
      end
      if (visible !== r.visible) begin
        $error("visible: expected %0b, actual %0b", r.visible, visible);
        errors++;
      end
    endfunction

    function int pending();
      return due_q.size();
    endfunction
  endclass

  cull_scoreboard sb = new();

  // Slots that some vertex has written, so that triangles never read an unwritten flag.
  bit          slot_written [VTX_DEPTH];
  int          written_q [$];
  int          last_vertex;
  bit          calm;
  int unsigned cycles;

  frustum_triangle_cull_top uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  // Clock of 20 ns period.
  always begin
    clk_i = 1'b0;
    #10;
    clk_i = 1'b1;
    #10;
  end

  // Run limit.
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // Receiver side: random stalls except during the calm stretch.
  always @(negedge clk_i) begin
    m_axis_tready <= calm || ($urandom_range(99) >= IDLE_PCT);
  end

  // Every result transaction is checked against the oldest expectation.
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      sb.check_result(m_axis_tuser[0], m_axis_tdata[0]);
    end
  end

  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] v);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= v;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    sb.write_reg(idx, v);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // Writes all six planes and the margin.
  task automatic load_config(input logic [CFG_DATA_W-1:0] pl [PLANE_CNT],
                             input logic [TOL_W-1:0] tol_v);
    for (int i = 0; i < PLANE_CNT; i++) begin
      cfg_write(CFG_IDX_W'(int'(CFG_PLANE_LEFT) + i), pl[i]);
    end
    cfg_write(CFG_TOLERANCE, {48'd0, tol_v});
  endtask

  // An axis-aligned box of random half size, with coefficients jittered around 1.0 so that
  // distances near a face are not whole multiples and the margin comes into play.
  task automatic load_box(input logic [TOL_W-1:0] tol_v);
    logic [CFG_DATA_W-1:0] pl [PLANE_CNT];
    logic [COEF_W-1:0]     half, k;
    half = COEF_W'($urandom_range(16'h0400, 16'h0800));
    for (int i = 0; i < PLANE_CNT; i++) begin
      k = COEF_W'(16'h00F8 + $urandom_range(0, 16));
      if (i % 2) k = -k;
      pl[i] = {-half, (i / 2 == 2) ? k : 16'h0, (i / 2 == 1) ? k : 16'h0,
               (i / 2 == 0) ? k : 16'h0};
    end
    load_config(pl, tol_v);
  endtask

  task automatic send_item(input kind_e k, input logic [IN_TDATA_W-1:0] data);
    @(negedge clk_i);
    while (!calm && $urandom_range(99) < IDLE_PCT) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= data;
    s_axis_tuser  <= k;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    sb.note_item(k, data);
  endtask

  // Corner fields carry junk, since a vertex ignores them.
  task automatic send_vertex(input int idx, input logic [COORD_W-1:0] x, y, z);
    logic [35:0] junk;
    junk = 36'({$urandom, $urandom});
    if (!slot_written[idx]) begin
      slot_written[idx] = 1'b1;
      written_q = {written_q, idx};
    end
    last_vertex = idx;
    send_item(KIND_VERTEX, {junk, z, y, x, IDX_W'(idx)});
  endtask

  // Index and coordinates carry junk, since a triangle ignores them.
  task automatic send_triangle(input int ca, cb, cc);
    logic [59:0] junk;
    junk = 60'({$urandom, $urandom});
    send_item(KIND_TRIANGLE, {IDX_W'(cc), IDX_W'(cb), IDX_W'(ca), junk});
  endtask

  // Lets the pipeline empty before the configuration changes or the run ends.
  task automatic drain();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (5) @(posedge clk_i);
  endtask

  function automatic int pick_corner();
    if ($urandom_range(3) == 0) return last_vertex;
    return written_q[$urandom_range(written_q.size() - 1)];
  endfunction

  initial begin
    logic [CFG_DATA_W-1:0] pl [PLANE_CNT];
    logic [TOL_W-1:0]      tol_v;
    logic [COORD_W-1:0]    x, y, z;

    rst_ni        = 1'b0;
    cfg_valid_i   = 1'b0;
    cfg_index_i   = '0;
    cfg_data_i    = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = '0;
    m_axis_tready = 1'b0;
    calm          = 1'b0;
    cycles        = 0;
    last_vertex   = 0;
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Reset planes are all zero, so every vertex passes whatever its coordinates.
    send_vertex(0, 16'h0000, 16'h0000, 16'h0000);
    send_vertex(4095, 16'h7FFF, 16'h7FFF, 16'h7FFF);
    send_vertex(2048, 16'h8000, 16'h8000, 16'h8000);
    send_triangle(0, 4095, 2048);
    drain();

    // One plane s = x in raw Q16.16 units: probes the margin of 7 at its edge.
    foreach (pl[i]) pl[i] = '0;
    pl[0] = {16'h0000, 16'h0000, 16'h0000, 16'h0001};
    load_config(pl, TOL_W'(7));
    send_vertex(1, 16'hFFF9, 16'h1234, 16'hABCD);
    send_vertex(2, 16'hFFF8, 16'h0000, 16'h0000);
    send_vertex(3, 16'h8000, 16'h0000, 16'h0000);
    send_vertex(4, 16'h7FFF, 16'h0000, 16'h0000);
    send_triangle(2, 3, 2);
    send_triangle(2, 3, 1);
    // A triangle right behind the vertex it reads.
    send_vertex(5, 16'hFFF8, 16'h0000, 16'h0000);
    send_triangle(5, 5, 5);
    send_vertex(2, 16'h0000, 16'h0000, 16'h0000);
    send_triangle(3, 2, 3);
    drain();

    // Extreme coefficients with the widest and the narrowest margin.
    foreach (pl[i]) pl[i] = 64'h8000_8000_8000_8000;
    load_config(pl, 16'hFFFF);
    send_vertex(6, 16'h7FFF, 16'h7FFF, 16'h7FFF);
    send_vertex(7, 16'h8000, 16'h8000, 16'h8000);
    send_triangle(6, 7, 6);
    drain();
    foreach (pl[i]) pl[i] = 64'h7FFF_7FFF_7FFF_7FFF;
    load_config(pl, 16'h0000);
    // The undecoded index must leave the configuration alone.
    cfg_write(CFG_UNUSED, {$urandom, $urandom});
    send_vertex(8, 16'h7FFF, 16'h7FFF, 16'h7FFF);
    send_vertex(9, 16'h8000, 16'h8000, 16'h8000);
    send_vertex(10, 16'h0000, 16'h0000, 16'h0000);
    send_triangle(9, 10, 8);
    drain();

    // Random phases, each under a fresh configuration.
    for (int ph = 0; ph < 7; ph++) begin
      calm = (ph == 3);
      tol_v = TOL_W'($urandom_range(0, 64));
      case (ph % 3)
        0: load_box(tol_v);
        1: load_box((ph % 2) ? 16'hFFFF : 16'h0000);
        default: begin
          foreach (pl[i]) pl[i] = {$urandom, $urandom};
          load_config(pl, TOL_W'($urandom));
        end
      endcase
      if (ph == 4) cfg_write(CFG_UNUSED, {$urandom, $urandom});
      for (int n = 0; n < 86; n++) begin
        if (written_q.size() == 0 || $urandom_range(99) < 55) begin
          if ($urandom_range(99) < 20) begin
            x = COORD_W'($urandom);
            y = COORD_W'($urandom);
            z = COORD_W'($urandom);
          end else begin
            x = COORD_W'($urandom_range(0, 4096) - 2048);
            y = COORD_W'($urandom_range(0, 4096) - 2048);
            z = COORD_W'($urandom_range(0, 4096) - 2048);
          end
          send_vertex($urandom_range(VTX_DEPTH - 1), x, y, z);
        end else begin
          send_triangle(pick_corner(), pick_corner(), pick_corner());
        end
      end
      drain();
    end
    calm = 1'b0;

    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
